// ===== hdl/jkar_pkg.sv =====
package jkar_pkg;

	localparam int NUM_KEYS = 36;
	localparam int IDX_W    = $clog2(NUM_KEYS);
	localparam int KEY_W    = 6;
	localparam int TIME_W   = 32;
	localparam int BASE_W   = 16;
	localparam int RNG_W    = 8;
	localparam int JIT_W    = 7;
	localparam int MASK_W   = 36;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = MASK_W;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic [RNG_W-1:0]  RNG_RESET  = 8'hAA;
	localparam logic [BASE_W-1:0] BASE_RESET = 16'd128;

	localparam logic [1:0] ACT_PRESS   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	localparam logic [2:0] KIND_HOST_PRESS   = 3'd0;
	localparam logic [2:0] KIND_HOST_RELEASE = 3'd1;
	localparam logic [2:0] KIND_HOST_TAP     = 3'd2;
	localparam logic [2:0] KIND_PASS_PRESS   = 3'd3;
	localparam logic [2:0] KIND_PASS_RELEASE = 3'd4;

	localparam logic [CFG_AW-1:0] CFG_ACTIVE = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_MASK   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_BASE   = 2'd2;

	typedef enum logic [2:0] {
		OP_PASS_PRESS,
		OP_PASS_RELEASE,
		OP_PRESS,
		OP_RELEASE,
		OP_TICK
	} op_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [KEY_W-1:0]  key_index;
		logic [TIME_W-1:0] now;
	} in_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [KEY_W-1:0] key;
		logic             last;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic              active;
		logic [MASK_W-1:0] mask;
		logic [BASE_W-1:0] base;
	} cfg_t;

	function automatic logic [RNG_W-1:0] rng_step(input logic [RNG_W-1:0] s,
		input logic [RNG_W-1:0] cnt);
		logic [RNG_W-1:0] a;
		logic [RNG_W-1:0] b;
		a = s ^ (s << 3);
		b = a ^ (a >> 5);
		return b ^ (cnt >> 2);
	endfunction

endpackage

// ===== hdl/jkar_front.sv =====
module jkar_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  jkar_pkg::in_t   item,
	input  jkar_pkg::cfg_t  cfg,
	output logic            cmd_valid,
	output jkar_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);
	import jkar_pkg::*;

	logic [63:0] mask_ext;
	logic        managed;
	logic        keep;
	logic        wr;
	cmd_t        cls;
	cmd_t        q_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	always_comb begin
		mask_ext = 64'(cfg.mask);
		managed  = cfg.active && ({1'b0, item.key_index} < (KEY_W+1)'(NUM_KEYS)) &&
			mask_ext[item.key_index];
		cls.key  = item.key_index;
		cls.now  = item.now;
		cls.op   = OP_PASS_PRESS;
		keep     = 1'b0;
		case (item.action)
			ACT_PRESS: begin
				keep   = 1'b1;
				cls.op = managed ? OP_PRESS : OP_PASS_PRESS;
			end
			ACT_RELEASE: begin
				keep   = 1'b1;
				cls.op = managed ? OP_RELEASE : OP_PASS_RELEASE;
			end
			ACT_TICK: begin
				keep   = cfg.active;
				cls.op = OP_TICK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (cmd_pop)
				rp_q <= !rp_q;
			case ({wr, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			q_q[wp_q] <= cls;
	end

endmodule

// ===== hdl/jkar_back.sv =====
module jkar_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jkar_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	input  jkar_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	input  logic            rq_full,
	output logic            rq_push,
	output jkar_pkg::out_t  rq_data
);
	import jkar_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [IDX_W-1:0]    idx_q;
	logic                pend_v_q;
	out_t                pend_q;
	logic [NUM_KEYS-1:0] held_q;
	logic [NUM_KEYS-1:0] ar_q;
	logic [NUM_KEYS-1:0] ttv_q;
	logic [RNG_W-1:0]    rng_q;
	logic [RNG_W-1:0]    cnt_q;
	logic [TIME_W-1:0]   tt_mem [NUM_KEYS];
	logic [TIME_W-1:0]   rd_q;

	logic [63:0]         mask_ext;
	logic [TIME_W-1:0]   tt_cur;
	logic                due;
	logic [RNG_W-1:0]    rng_nx;
	logic [TIME_W-1:0]   deadline;
	logic                rel_hit;
	logic                last_idx;
	logic                step_ok;
	logic                done;
	logic                tt_we;
	logic [IDX_W-1:0]    rd_addr;

	always_comb begin
		mask_ext = 64'(cfg.mask);
		tt_cur   = ttv_q[idx_q] ? rd_q : '0;
		due      = mask_ext[idx_q] && held_q[idx_q] && (tt_cur <= cmd_q.now);
		rng_nx   = rng_step(rng_q, cnt_q);
		deadline = cmd_q.now + TIME_W'(cfg.base) + TIME_W'(rng_nx[JIT_W-1:0]);
		rel_hit  = (cmd_q.now < tt_cur) && !ar_q[idx_q];
		last_idx = (idx_q == IDX_W'(NUM_KEYS-1));
		step_ok  = !due || !pend_v_q || !rq_full;
		cmd_pop  = 1'b0;
		rq_push  = 1'b0;
		rq_data  = '{kind: KIND_HOST_PRESS, key: cmd_q.key, last: 1'b1};
		done     = 1'b0;
		tt_we    = 1'b0;
		rd_addr  = idx_q;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				rd_addr = (cmd.op == OP_RELEASE) ? cmd.key[IDX_W-1:0] : '0;
			end
			ST_EXEC: begin
				case (cmd_q.op)
					OP_PASS_PRESS: begin
						rq_push      = !rq_full;
						rq_data.kind = KIND_PASS_PRESS;
						done         = !rq_full;
					end
					OP_PASS_RELEASE: begin
						rq_push      = !rq_full;
						rq_data.kind = KIND_PASS_RELEASE;
						done         = !rq_full;
					end
					OP_PRESS: begin
						rq_push      = !rq_full;
						rq_data.kind = KIND_HOST_PRESS;
						done         = !rq_full;
						tt_we        = !rq_full;
					end
					OP_RELEASE: begin
						rq_push      = rel_hit && !rq_full;
						rq_data.kind = KIND_HOST_RELEASE;
						done         = !rel_hit || !rq_full;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			ST_SCAN: begin
				rq_push = due && pend_v_q && !rq_full;
				rq_data = '{kind: pend_q.kind, key: pend_q.key, last: 1'b0};
				tt_we   = due && step_ok;
				if (step_ok && !last_idx)
					rd_addr = idx_q + IDX_W'(1);
			end
			ST_FLUSH: begin
				rq_push = pend_v_q && !rq_full;
				rq_data = '{kind: pend_q.kind, key: pend_q.key, last: 1'b1};
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			held_q   <= '0;
			ar_q     <= '0;
			ttv_q    <= '0;
			rng_q    <= RNG_RESET;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						idx_q   <= (cmd.op == OP_PRESS || cmd.op == OP_RELEASE) ?
							cmd.key[IDX_W-1:0] : '0;
						state_q <= (cmd.op == OP_TICK) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q <= ST_IDLE;
						if (cmd_q.op == OP_PRESS) begin
							held_q[idx_q] <= 1'b1;
							ar_q[idx_q]   <= 1'b0;
							ttv_q[idx_q]  <= 1'b1;
							rng_q         <= rng_nx;
							cnt_q         <= cnt_q + RNG_W'(1);
						end
						if (cmd_q.op == OP_RELEASE)
							held_q[idx_q] <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (step_ok) begin
						if (due) begin
							pend_q.kind  <= ar_q[idx_q] ? KIND_HOST_TAP : KIND_HOST_RELEASE;
							pend_q.key   <= KEY_W'(idx_q);
							pend_q.last  <= 1'b0;
							pend_v_q     <= 1'b1;
							ar_q[idx_q]  <= 1'b1;
							ttv_q[idx_q] <= 1'b1;
							rng_q        <= rng_nx;
							cnt_q        <= cnt_q + RNG_W'(1);
						end
						if (last_idx)
							state_q <= ST_FLUSH;
						else
							idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || !rq_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tt_we)
			tt_mem[idx_q] <= deadline;
		rd_q <= tt_mem[rd_addr];
	end

endmodule

// ===== hdl/jkar_rq.sv =====
module jkar_rq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  jkar_pkg::out_t  data,
	output logic            full,
	output logic            empty,
	input  logic            pop,
	output jkar_pkg::out_t  result
);
	import jkar_pkg::*;

	out_t             q_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wp_q;
	logic [RQ_AW-1:0] rp_q;
	logic [RQ_AW:0]   cnt_q;
	logic             rd;

	assign full   = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd     = pop && !empty;
	assign result = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + RQ_AW'(1);
			if (rd)
				rp_q <= rp_q + RQ_AW'(1);
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (RQ_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (RQ_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			q_q[wp_q] <= data;
	end

endmodule

// ===== hdl/jittered_key_auto_repeat.sv =====
// Auto-repeat of held keys with a randomized repeat interval.
// Input queue side: drive item and raise push; the item transfers on a clock
// edge with push high and full low. Actions are press, release and tick.
// Result queue side: while empty is low, result shows the oldest event; it
// transfers on a clock edge with pop high. The last flag marks the final event
// caused by one input item.
// Configuration: cfg_index selects active flag, enable mask or base delay;
// cfg_data is written when cfg_valid and cfg_ready are high (ready is always
// high). Write only while the block is idle.
// Processing: a press, release or passthrough command passes through the idle
// and execute states of the back end; its result is visible in the cycle after
// it enters the result queue. A tick scans every key once through the
// trigger-time memory at one key per cycle while the result queue has room.
// A two-entry command queue lets the next items transfer while the scan runs.
// Reset clears all key state, reseeds the random generator and empties both
// queues. When the receiver stalls, the result queue fills, then the back end
// holds its scan in place, then full rises on the input side.
module jittered_key_auto_repeat (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  jkar_pkg::in_t                 item,
	output logic                          empty,
	input  logic                          pop,
	output jkar_pkg::out_t                result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [jkar_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [jkar_pkg::CFG_DW-1:0]   cfg_data
);
	import jkar_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic rq_full;
	logic rq_push;
	out_t rq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active <= 1'b0;
			cfg_q.mask   <= '0;
			cfg_q.base   <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE: cfg_q.active <= cfg_data[0];
				CFG_MASK:   cfg_q.mask   <= cfg_data[MASK_W-1:0];
				CFG_BASE:   cfg_q.base   <= cfg_data[BASE_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	jkar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	jkar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rq_full   (rq_full),
		.rq_push   (rq_push),
		.rq_data   (rq_data)
	);

	jkar_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.data   (rq_data),
		.full   (rq_full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== hdl/jkar_checker.sv =====
module jkar_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input jkar_pkg::out_t result
);
	import jkar_pkg::*;

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.kind <= KIND_PASS_RELEASE)
		else $error("result kind out of range");

	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.kind == KIND_PASS_PRESS || result.kind == KIND_PASS_RELEASE)
		|-> result.last)
		else $error("passthrough event without last flag");

	a_host_key: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind <= KIND_HOST_TAP
		|-> {1'b0, result.key} < (KEY_W+1)'(NUM_KEYS))
		else $error("host event for key out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result changed");

endmodule

bind jittered_key_auto_repeat jkar_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
